/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the sphere union volume block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/tsu_pkg.sv */
// Package for the sphere union volume block: widths, constants, types.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tsu_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CW        = 28;
  localparam int RW        = 24;
  localparam int DW        = 29;
  localparam int D2W       = 58;
  localparam int VW        = 44;
  localparam int QNW       = 77;
  localparam int NW        = 102;
  localparam int SW        = 25;
  localparam int VOL_SHIFT = 2 * FRAC_BITS + 40;
  localparam logic [38:0] PI12_Q40 = 39'd287851471030;
  localparam int MUL_AW = 96;
  localparam int MUL_BW = 64;
  localparam int MUL_PW = 160;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CASE_DISJOINT = 2'd0,
    CASE_INSIDE   = 2'd1,
    CASE_PARTIAL  = 2'd2
  } case_t;

  // One classified sphere pair handed from the front to the back.
  typedef struct packed {
    logic [RW-1:0] ra;
    logic [RW-1:0] rb;
    logic [DW-1:0] d;
    case_t         kase;
  } pair_t;

  // Queue status seen by the top level and the back part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

/* sv/two_sphere_union_volume_unit.sv */
// Union volume of two spheres: one word accepted per cycle when start is high and busy low.
// The longest parts of the pipeline are the 29-stage square root and the 77-stage divider.
// Throughput is one word per cycle while busy is low; the wide multiplies are three-stage partial-product units.
// The receiver cannot stall: each result shows for one cycle with done high.
// Synchronous reset clears all valid bits and the queue; no result is pending after it.
`timescale 1ns / 1ps
`default_nettype none
module two_sphere_union_volume_unit
  import tsu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [CW-1:0] center_a_x,
  input  wire logic [CW-1:0] center_a_y,
  input  wire logic [CW-1:0] center_a_z,
  input  wire logic [RW-1:0] radius_a,
  input  wire logic [CW-1:0] center_b_x,
  input  wire logic [CW-1:0] center_b_y,
  input  wire logic [CW-1:0] center_b_z,
  input  wire logic [RW-1:0] radius_b,
  output logic               done,
  output logic [VW-1:0]      union_volume,
  output logic [1:0]         overlap_case
);
  logic    push;
  pair_t   f_item, q_item;
  q_stat_t q_stat;
  logic    pop;

  // Back part never stalls, so it drains the queue whenever a word waits.
  assign busy = q_stat.full;
  assign pop  = !q_stat.empty;

  tsu_front u_front (
    .clk(clk), .rst(rst), .take(start && !busy),
    .center_a_x(center_a_x), .center_a_y(center_a_y), .center_a_z(center_a_z),
    .radius_a(radius_a),
    .center_b_x(center_b_x), .center_b_y(center_b_y), .center_b_z(center_b_z),
    .radius_b(radius_b),
    .push(push), .item(f_item)
  );

  tsu_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_item),
    .pop(pop), .rdata(q_item), .stat(q_stat)
  );

  tsu_back u_back (
    .clk(clk), .rst(rst), .in_valid(pop), .in_item(q_item),
    .done(done), .union_volume(union_volume), .overlap_case(overlap_case)
  );
endmodule
`default_nettype wire

/* sv/tsu_front.sv */
// Front part: center differences, squared distance, pipelined square root
// and case classification. Depends on tsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsu_front
  import tsu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [CW-1:0] center_a_x,
  input  wire logic [CW-1:0] center_a_y,
  input  wire logic [CW-1:0] center_a_z,
  input  wire logic [RW-1:0] radius_a,
  input  wire logic [CW-1:0] center_b_x,
  input  wire logic [CW-1:0] center_b_y,
  input  wire logic [CW-1:0] center_b_z,
  input  wire logic [RW-1:0] radius_b,
  output logic               push,
  output pair_t              item
);
  logic [CW:0]   dx, dy, dz;
  logic          v1, v2, v3;
  logic [CW-1:0] ax, ay, az;
  logic [RW-1:0] ra1, rb1, ra2, rb2, ra3, rb3;
  logic [2*CW-1:0] sx, sy, sz;
  logic [D2W-1:0]  d2;

  logic [D2W:0]  rem_s  [0:DW];
  logic [DW-1:0] root_s [0:DW];
  logic [RW-1:0] sra_s  [0:DW];
  logic [RW-1:0] srb_s  [0:DW];
  logic          sv_s   [0:DW];

  // Signed differences; magnitudes always fit the field width.
  assign dx = {center_a_x[CW-1], center_a_x} - {center_b_x[CW-1], center_b_x};
  assign dy = {center_a_y[CW-1], center_a_y} - {center_b_y[CW-1], center_b_y};
  assign dz = {center_a_z[CW-1], center_a_z} - {center_b_z[CW-1], center_b_z};

  function automatic logic [CW-1:0] mag(input logic [CW:0] v);
    logic [CW:0] n;
    n = ~v + 1'b1;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  // Stage 1 to 3: magnitudes, squares, sum of squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
    ax  <= mag(dx);
    ay  <= mag(dy);
    az  <= mag(dz);
    ra1 <= radius_a;
    rb1 <= radius_b;
    sx  <= ax * ax;
    sy  <= ay * ay;
    sz  <= az * az;
    ra2 <= ra1;
    rb2 <= rb1;
    d2  <= {2'd0, sx} + {2'd0, sy} + {2'd0, sz};
    ra3 <= ra2;
    rb3 <= rb2;
  end

  assign rem_s[0]  = {1'b0, d2};
  assign root_s[0] = '0;
  assign sra_s[0]  = ra3;
  assign srb_s[0]  = rb3;
  assign sv_s[0]   = v3;

  // Square root, one result bit per stage, remainder kept as v - root^2.
  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    localparam int B = DW - 1 - k;
    logic [D2W:0] trial;
    assign trial = ({{(D2W + 1 - DW){1'b0}}, root_s[k]} << (B + 1))
                 + ((D2W + 1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv_s[k+1] <= 1'b0;
      end else begin
        sv_s[k+1] <= sv_s[k];
      end
      if (rem_s[k] >= trial) begin
        rem_s[k+1]  <= rem_s[k] - trial;
        root_s[k+1] <= root_s[k] | (DW'(1) << B);
      end else begin
        rem_s[k+1]  <= rem_s[k];
        root_s[k+1] <= root_s[k];
      end
      sra_s[k+1] <= sra_s[k];
      srb_s[k+1] <= srb_s[k];
    end
  end

  logic [DW-1:0] droot;
  logic [SW-1:0] ssum;
  logic [RW-1:0] mn, mx;
  case_t         kase;
  assign droot = root_s[DW];
  assign ssum  = {1'b0, sra_s[DW]} + {1'b0, srb_s[DW]};
  assign mn    = (sra_s[DW] < srb_s[DW]) ? sra_s[DW] : srb_s[DW];
  assign mx    = (sra_s[DW] < srb_s[DW]) ? srb_s[DW] : sra_s[DW];

  // Classification on the floored distance.
  always_comb begin
    if (droot >= {{(DW - SW){1'b0}}, ssum}) begin
      kase = CASE_DISJOINT;
    end else if (({{(DW + 1 - RW){1'b0}}, mn} + {1'b0, droot})
                 <= {{(DW + 1 - RW){1'b0}}, mx}) begin
      kase = CASE_INSIDE;
    end else begin
      kase = CASE_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= sv_s[DW];
    end
    item.ra   <= sra_s[DW];
    item.rb   <= srb_s[DW];
    item.d    <= droot;
    item.kase <= kase;
  end
endmodule
`default_nettype wire

/* sv/tsu_queue.sv */
// Short word queue between the front and back parts.
// Depends on tsu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tsu_queue
  import tsu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire pair_t wdata,
  input  wire logic  pop,
  output pair_t      rdata,
  output q_stat_t    stat
);
  pair_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign stat.full  = (count == (QAW + 1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rd_ptr];

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && stat.full && !pop)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && stat.empty)
  `ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
endmodule
`default_nettype wire

/* sv/tsu_mul.sv */
// Three-stage multiplier built from 32x32 partial products.
// Depends on tsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsu_mul
  import tsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [MUL_AW-1:0] a,
  input  wire logic [MUL_BW-1:0] b,
  output logic      [MUL_PW-1:0] p
);
  localparam int NA = MUL_AW / 32;
  localparam int NB = MUL_BW / 32;
  logic [63:0] pp  [NA][NB];
  logic [95:0] row [NA];

  // Partial products, then row sums, then the final sum.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= a[32*i +: 32] * b[32*j +: 32];
      end
      row[i] <= {32'd0, pp[i][0]} + {pp[i][1], 32'd0};
    end
    p <= {64'd0, row[0]} + {32'd0, row[1], 32'd0} + {row[2], 64'd0};
  end
endmodule
`default_nettype wire

/* sv/tsu_back.sv */
// Back part: cubes, lens volume, division by the distance, scaling by pi.
// Depends on tsu_pkg and tsu_mul.
`timescale 1ns / 1ps
`default_nettype none
module tsu_back
  import tsu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire pair_t         in_item,
  output logic               done,
  output logic [VW-1:0]      union_volume,
  output logic [1:0]         overlap_case
);
  typedef struct packed {
    logic          age;
    logic [SW-1:0] d;
    case_t         kase;
  } side1_t;

  typedef struct packed {
    logic [NW-1:0]  lens;
    logic [QNW-1:0] tmx;
    logic [SW-1:0]  d;
    case_t          kase;
  } side2_t;

  // Stage B1: sums, maxima and the narrow products.
  logic          b1_v, b1_age;
  logic [RW-1:0] b1_ra, b1_rb;
  logic [SW-1:0] b1_d, b1_sd;
  case_t         b1_kase;
  logic [2*SW-1:0] b1_dd, b1_ds;
  logic [2*RW-1:0] b1_qq, b1_ra2, b1_rb2;
  logic [SW-1:0] s_in, d_in;
  logic [RW-1:0] q_in;

  assign d_in = in_item.d[SW-1:0];
  assign s_in = {1'b0, in_item.ra} + {1'b0, in_item.rb};
  assign q_in = (in_item.ra >= in_item.rb) ? (in_item.ra - in_item.rb)
                                           : (in_item.rb - in_item.ra);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else begin
      b1_v <= in_valid;
    end
    b1_ra   <= in_item.ra;
    b1_rb   <= in_item.rb;
    b1_age  <= in_item.ra >= in_item.rb;
    b1_d    <= d_in;
    b1_kase <= in_item.kase;
    b1_sd   <= s_in - d_in;
    b1_dd   <= d_in * d_in;
    b1_ds   <= d_in * s_in;
    b1_qq   <= q_in * q_in;
    b1_ra2  <= in_item.ra * in_item.ra;
    b1_rb2  <= in_item.rb * in_item.rb;
  end

  // Stage B2: second lens factor and squared gap.
  logic            b2_v;
  side1_t          b2_side;
  logic [RW-1:0]   b2_ra, b2_rb;
  logic [2*RW-1:0] b2_ra2, b2_rb2;
  logic [2*SW-1:0] b2_sd2;
  logic [51:0]     b2_bterm;
  logic [2*RW+1:0] qq3;
  logic [52:0]     bsum;

  assign qq3  = {1'b0, b1_qq, 1'b0} + {2'b00, b1_qq};
  assign bsum = {3'd0, b1_dd} + {2'd0, b1_ds, 1'b0} - {3'd0, qq3};

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else begin
      b2_v <= b1_v;
    end
    b2_side  <= '{age: b1_age, d: b1_d, kase: b1_kase};
    b2_ra    <= b1_ra;
    b2_rb    <= b1_rb;
    b2_ra2   <= b1_ra2;
    b2_rb2   <= b1_rb2;
    b2_sd2   <= b1_sd * b1_sd;
    b2_bterm <= bsum[51:0];
  end

  // Cubes and lens product.
  logic [MUL_PW-1:0] m_ra3, m_rb3, m_lens;
  tsu_mul u_mul_ra3 (.clk(clk), .a({48'd0, b2_ra2}), .b({40'd0, b2_ra}), .p(m_ra3));
  tsu_mul u_mul_rb3 (.clk(clk), .a({48'd0, b2_rb2}), .b({40'd0, b2_rb}), .p(m_rb3));
  tsu_mul u_mul_lens (.clk(clk), .a({46'd0, b2_sd2}), .b({12'd0, b2_bterm}), .p(m_lens));

  logic   d1_v    [3];
  side1_t d1_side [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) d1_v[i] <= 1'b0;
    end else begin
      d1_v[0] <= b2_v;
      for (int i = 1; i < 3; i++) d1_v[i] <= d1_v[i-1];
    end
    d1_side[0] <= b2_side;
    for (int i = 1; i < 3; i++) d1_side[i] <= d1_side[i-1];
  end

  // Stage B6: scaled sum of cubes and scaled larger cube.
  logic           b6_v;
  logic [QNW-1:0] b6_t;
  side2_t         b6_side;
  logic [72:0]    csum;
  assign csum = {1'b0, m_ra3[71:0]} + {1'b0, m_rb3[71:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      b6_v <= 1'b0;
    end else begin
      b6_v <= d1_v[2];
    end
    b6_t         <= {csum, 4'd0};
    b6_side.lens <= m_lens[NW-1:0];
    b6_side.tmx  <= {1'b0, (d1_side[2].age ? m_ra3[71:0] : m_rb3[71:0]), 4'd0};
    b6_side.d    <= d1_side[2].d;
    b6_side.kase <= d1_side[2].kase;
  end

  // Total times distance.
  logic [MUL_PW-1:0] m_td;
  tsu_mul u_mul_td (.clk(clk), .a({19'd0, b6_t}), .b({39'd0, b6_side.d}), .p(m_td));

  logic   d2_v    [3];
  side2_t d2_side [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) d2_v[i] <= 1'b0;
    end else begin
      d2_v[0] <= b6_v;
      for (int i = 1; i < 3; i++) d2_v[i] <= d2_v[i-1];
    end
    d2_side[0] <= b6_side;
    for (int i = 1; i < 3; i++) d2_side[i] <= d2_side[i-1];
  end

  // Sum of cubes for the disjoint case is carried alongside the lens side data.
  logic [QNW-1:0] t_dly [3];
  always_ff @(posedge clk) begin
    t_dly[0] <= b6_t;
    for (int i = 1; i < 3; i++) t_dly[i] <= t_dly[i-1];
  end

  // Divider, one quotient bit per stage; remainder rides in the top bits.
  logic [NW-1:0]  w_s    [0:QNW];
  logic [SW-1:0]  dv_s   [0:QNW];
  logic [QNW-1:0] qalt_s [0:QNW];
  case_t          kase_s [0:QNW];
  logic           v_s    [0:QNW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= d2_v[2];
    end
    w_s[0]    <= m_td[NW-1:0] - d2_side[2].lens;
    dv_s[0]   <= d2_side[2].d;
    qalt_s[0] <= (d2_side[2].kase == CASE_DISJOINT) ? t_dly[2] : d2_side[2].tmx;
    kase_s[0] <= d2_side[2].kase;
  end

  for (genvar k = 0; k < QNW; k++) begin : g_div
    logic [SW+1:0] trial;
    assign trial = {1'b0, w_s[k][NW-1:QNW-1]} - {2'b00, dv_s[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
      if (!trial[SW+1]) begin
        w_s[k+1] <= {trial[SW-1:0], w_s[k][QNW-2:0], 1'b1};
      end else begin
        w_s[k+1] <= {w_s[k][NW-2:0], 1'b0};
      end
      dv_s[k+1]   <= dv_s[k];
      qalt_s[k+1] <= qalt_s[k];
      kase_s[k+1] <= kase_s[k];
    end
  end

  // Select the scaled volume for the case.
  logic           qn_v;
  logic [QNW-1:0] qn;
  case_t          qn_kase;
  always_ff @(posedge clk) begin
    if (rst) begin
      qn_v <= 1'b0;
    end else begin
      qn_v <= v_s[QNW];
    end
    qn      <= (kase_s[QNW] == CASE_PARTIAL) ? w_s[QNW][QNW-1:0] : qalt_s[QNW];
    qn_kase <= kase_s[QNW];
  end

  // Scale by pi/12, round half up and saturate.
  logic [MUL_PW-1:0] m_vol, vsum, vshift;
  tsu_mul u_mul_pi (.clk(clk), .a({19'd0, qn}), .b({25'd0, PI12_Q40}), .p(m_vol));

  logic  d3_v    [3];
  case_t d3_kase [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) d3_v[i] <= 1'b0;
    end else begin
      d3_v[0] <= qn_v;
      for (int i = 1; i < 3; i++) d3_v[i] <= d3_v[i-1];
    end
    d3_kase[0] <= qn_kase;
    for (int i = 1; i < 3; i++) d3_kase[i] <= d3_kase[i-1];
  end

  assign vsum   = m_vol + (MUL_PW'(1) << (VOL_SHIFT - 1));
  assign vshift = vsum >> VOL_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d3_v[2];
    end
    union_volume <= (|vshift[MUL_PW-1:VW]) ? {VW{1'b1}} : vshift[VW-1:0];
    overlap_case <= d3_kase[2];
  end
endmodule
`default_nettype wire

/* tb/sv/two_sphere_union_volume_unit_test.sv */
// Self-checking bench for the sphere union volume unit: directed table, then random words.
// Depends on tsu_pkg and two_sphere_union_volume_unit; needs no files at run time.
`timescale 1ns / 1ps
module two_sphere_union_volume_unit_test;
  import tsu_pkg::*;

  localparam int N_RANDOM  = 650;
  localparam int CYC_LIMIT = 400000;
  localparam logic [VW-1:0] VOL_SAT = {VW{1'b1}};

  // One input word: two centers and two radii.
  typedef struct {
    logic [CW-1:0] ax, ay, az, bx, by, bz;
    logic [RW-1:0] ra, rb;
  } spheres_t;

  typedef struct {
    logic [VW-1:0] vol;
    case_t         kase;
  } union_t;

  // Directed row: a pair plus an optional literal expectation.
  typedef struct {
    spheres_t sp;
    bit       has_lit;
    union_t   lit;
  } row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [CW-1:0] center_a_x, center_a_y, center_a_z, center_b_x, center_b_y, center_b_z;
  logic [RW-1:0] radius_a, radius_b;
  logic          done;
  logic [VW-1:0] union_volume;
  logic [1:0]    overlap_case;

  union_t pending_volumes[$];
  int     n_fail;
  int     n_sent;
  int     n_seen;
  int     n_case[3];
  longint cyc;

  two_sphere_union_volume_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .center_a_x(center_a_x), .center_a_y(center_a_y), .center_a_z(center_a_z),
    .radius_a(radius_a),
    .center_b_x(center_b_x), .center_b_y(center_b_y), .center_b_z(center_b_z),
    .radius_b(radius_b),
    .done(done), .union_volume(union_volume), .overlap_case(overlap_case)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Integer square root, floored, bit by bit.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Squared difference of two signed coordinates.
  function automatic logic [63:0] coord_sq(input logic [CW-1:0] a, input logic [CW-1:0] b);
    longint t;
    t = longint'($signed(a)) - longint'($signed(b));
    if (t < 0) t = -t;
    return 64'(t) * 64'(t);
  endfunction

  // Expected union volume and case for one pair, exact in wide integers.
  function automatic union_t union_of(input spheres_t sp);
    logic [255:0] ra, rb, d, s, mn, mx, q, qn, cubes, lens, bterm, prod;
    logic [63:0]  d2;
    union_t       r;
    ra = sp.ra;
    rb = sp.rb;
    d2 = coord_sq(sp.ax, sp.bx) + coord_sq(sp.ay, sp.by) + coord_sq(sp.az, sp.bz);
    d = floor_sqrt(d2);
    s = ra + rb;
    mn = (ra < rb) ? ra : rb;
    mx = (ra < rb) ? rb : ra;
    cubes = ra * ra * ra + rb * rb * rb;
    if (d >= s) begin
      r.kase = CASE_DISJOINT;
      qn = 16 * cubes;
    end else if (mn + d <= mx) begin
      r.kase = CASE_INSIDE;
      qn = 16 * mx * mx * mx;
    end else begin
      r.kase = CASE_PARTIAL;
      q = mx - mn;
      bterm = d * d + 2 * d * s - 3 * q * q;
      lens = (s - d) * (s - d) * bterm;
      qn = (16 * cubes * d - lens) / d;
    end
    prod = (qn * PI12_Q40 + (256'd1 << (VOL_SHIFT - 1))) >> VOL_SHIFT;
    r.vol = (prod > VOL_SAT) ? VOL_SAT : prod[VW-1:0];
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(0, 64 << FRAC_BITS)) - (32 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [RW-1:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return RW'($urandom);
      1: return $urandom_range(0, 1) ? {RW{1'b1}} : '0;
      default: return RW'($urandom_range(0, 6 << FRAC_BITS));
    endcase
  endfunction

  // Random pair, mostly placed so the spheres are near each other.
  function automatic spheres_t rand_pair();
    spheres_t sp;
    int       off;
    sp.ax = rand_coord(); sp.ay = rand_coord(); sp.az = rand_coord();
    sp.ra = rand_radius(); sp.rb = rand_radius();
    if ($urandom_range(0, 3) != 0) begin
      off = 4 << FRAC_BITS;
      sp.bx = sp.ax + CW'($signed($urandom_range(0, 2 * off)) - off);
      sp.by = sp.ay + CW'($signed($urandom_range(0, 2 * off)) - off);
      sp.bz = sp.az + CW'($signed($urandom_range(0, 2 * off)) - off);
    end else begin
      sp.bx = rand_coord(); sp.by = rand_coord(); sp.bz = rand_coord();
    end
    return sp;
  endfunction

  function automatic spheres_t mk(input int ax, ay, az, ra, bx, by, bz, rb);
    spheres_t sp;
    sp.ax = CW'(ax); sp.ay = CW'(ay); sp.az = CW'(az); sp.ra = RW'(ra);
    sp.bx = CW'(bx); sp.by = CW'(by); sp.bz = CW'(bz); sp.rb = RW'(rb);
    return sp;
  endfunction

  // Send one word: hold start until the unit takes it.
  task automatic send_word(input spheres_t sp, input bit has_lit, input union_t lit);
    union_t want;
    center_a_x <= sp.ax; center_a_y <= sp.ay; center_a_z <= sp.az; radius_a <= sp.ra;
    center_b_x <= sp.bx; center_b_y <= sp.by; center_b_z <= sp.bz; radius_b <= sp.rb;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = has_lit ? lit : union_of(sp);
    pending_volumes.push_back(want);
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = 0;
      5, 6, 7, 8:    n = $urandom_range(1, 3);
      default:       n = $urandom_range(10, 60);
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Result check: compare each strobed word against the oldest expectation.
  always @(posedge clk) begin
    union_t want;
    if (!rst && done) begin
      if (pending_volumes.size() == 0) begin
        $error("result with no expectation: union_volume %0d", union_volume);
        n_fail++;
      end else begin
        want = pending_volumes.pop_front();
        if (union_volume !== want.vol) begin
          $error("union_volume expected %0d actual %0d", want.vol, union_volume);
          n_fail++;
        end
        if (overlap_case !== want.kase) begin
          $error("overlap_case expected %0d actual %0d", want.kase, overlap_case);
          n_fail++;
        end
        if (overlap_case < 3) n_case[overlap_case]++;
        n_seen++;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t   rows[$];
    row_t   rw;
    union_t none;
    int     one;
    int     maxc;
    int     minc;
    int     tail;
    one  = 1 << FRAC_BITS;
    maxc = (1 << (CW - 1)) - 1;
    minc = -(1 << (CW - 1));
    none.vol = '0;
    none.kase = CASE_DISJOINT;
    n_fail = 0; n_sent = 0; n_seen = 0; cyc = 0;
    n_case[0] = 0; n_case[1] = 0; n_case[2] = 0;
    rst = 1'b1;
    start = 1'b0;
    center_a_x = '0; center_a_y = '0; center_a_z = '0; radius_a = '0;
    center_b_x = '0; center_b_y = '0; center_b_z = '0; radius_b = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; literal results only where obvious.
    // Zero radii give a zero sum, so any distance counts as disjoint.
    rw.has_lit = 1'b1;
    rw.lit.vol = '0; rw.lit.kase = CASE_DISJOINT;
    rw.sp = mk(0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(rw);          // two points together
    rw.sp = mk(0, 0, 0, 0, one, 0, 0, 0); rows.push_back(rw);        // two points apart
    rw.sp = mk(minc, minc, minc, 0, maxc, maxc, maxc, 0); rows.push_back(rw);
    rw.has_lit = 1'b0; rw.lit = none;
    rw.sp = mk(0, 0, 0, one, 0, 0, 0, one); rows.push_back(rw);      // coincident equal spheres
    rw.sp = mk(0, 0, 0, 0, one, 0, 0, 2 * one); rows.push_back(rw);  // point inside sphere
    rw.sp = mk(0, 0, 0, 0, 2 * one, 0, 0, 2 * one); rows.push_back(rw); // point on surface
    rw.sp = mk(0, 0, 0, 0, 3 * one, 0, 0, 2 * one); rows.push_back(rw); // point outside
    rw.sp = mk(0, 0, 0, one, 2 * one, 0, 0, one); rows.push_back(rw); // touching outside
    rw.sp = mk(0, 0, 0, 3 * one, one, 0, 0, 2 * one); rows.push_back(rw); // touching inside
    rw.sp = mk(0, 0, 0, one, one, 0, 0, one); rows.push_back(rw);    // partial, equal radii
    rw.sp = mk(0, 0, 0, 3 * one, 0, 2 * one, 0, one); rows.push_back(rw); // touching inside, unequal radii
    rw.sp = mk(0, 0, 0, 2 * one, 0, 0, 1, 2 * one); rows.push_back(rw); // partial, d of one
    rw.sp = mk(0, 0, 0, (1 << RW) - 1, 0, 0, 0, (1 << RW) - 1); rows.push_back(rw);
    rw.sp = mk(0, 0, 0, (1 << RW) - 1, 0, 0, 0, 0); rows.push_back(rw);
    rw.sp = mk(maxc, maxc, maxc, (1 << RW) - 1, minc, minc, minc, (1 << RW) - 1);
    rows.push_back(rw);
    rw.sp = mk(maxc, minc, maxc, (1 << RW) - 1, maxc - (1 << 24), minc, maxc, (1 << RW) - 1);
    rows.push_back(rw);
    rw.sp = mk(-one, -one, -one, one, one, one, one, 2 * one); rows.push_back(rw);
    rw.sp = mk(5, -7, 9, 1, -3, 2, 8, 12); rows.push_back(rw);
    foreach (rows[i]) begin
      send_word(rows[i].sp, rows[i].has_lit, rows[i].lit);
      if (i % 4 == 3) idle_gap();
    end

    // Random words; partway through, drain everything before resuming.
    for (int i = 0; i < N_RANDOM; i++) begin
      send_word(rand_pair(), 1'b0, none);
      if (i < 60) continue;
      idle_gap();
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending_volumes.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    // Drain and let any stray result show.
    while (pending_volumes.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 200) begin
      @(posedge clk);
      tail++;
    end

    $display("Sent %0d pairs, checked %0d results.", n_sent, n_seen);
    $display("Cases: %0d disjoint, %0d inside, %0d partial.", n_case[0], n_case[1], n_case[2]);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
